// File: rtl/error_diffusion_braille_packer_macros.svh
// Assertion macros used by the checker of the braille packer.
`ifndef ERROR_DIFFUSION_BRAILLE_PACKER_MACROS_SVH
`define ERROR_DIFFUSION_BRAILLE_PACKER_MACROS_SVH

// The consequent is checked at the same clock edge as the antecedent.
`define EDBP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edbp: same-edge property failed");

// The consequent is checked at the clock edge after the antecedent.
`define EDBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edbp: next-edge property failed");

`endif

// File: rtl/edbp_pkg.sv
// Shared types, constants and helper functions of the braille packer.
package edbp_pkg;

    localparam int ERR_W        = 11;
    localparam int LINE_WIDTH_W = 11;
    localparam int CFG_INDEX_W  = 1;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 32;
    localparam int RESULT_W     = 25;

    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd640;
    localparam int MIN_LINE_WIDTH = 2;

    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic signed [ERR_W:0]   err_wide_t;

    localparam err_t      ERR_ZERO    = '0;
    localparam err_wide_t ERR_MAX     = 12'sd1023;
    localparam err_wide_t ERR_MIN     = -12'sd1024;
    localparam err_wide_t THRESHOLD   = 12'sd128;
    localparam err_wide_t WHITE_LEVEL = 12'sd255;

    localparam logic [2:0] LAST_POS = 3'd7;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINE_WIDTH  = 1'b0,
        CFG_INVERT_DOTS = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] cell_row;
        logic [8:0] cell_column;
        logic [7:0] braille_dots;
    } cell_result_t;

    typedef struct packed {
        logic empty;
        logic full;
    } buf_status_t;

    function automatic err_t sat_err(input err_wide_t v);
        err_t r;
        if (v > ERR_MAX)
        begin
            r = err_t'(ERR_MAX);
        end
        else if (v < ERR_MIN)
        begin
            r = err_t'(ERR_MIN);
        end
        else
        begin
            r = err_t'(v);
        end
        return r;
    endfunction

    // Dot numbering of a braille cell for pixel position {row[1:0], column[0]}.
    function automatic logic [7:0] dot_mask(input logic [2:0] pos);
        logic [7:0] m;
        case (pos)
            3'd0:    m = 8'h01;
            3'd1:    m = 8'h08;
            3'd2:    m = 8'h02;
            3'd3:    m = 8'h10;
            3'd4:    m = 8'h04;
            3'd5:    m = 8'h20;
            3'd6:    m = 8'h40;
            3'd7:    m = 8'h80;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/error_diffusion_braille_packer.sv
// Error-diffusion dither of a grey pixel stream packed into braille cells.
// Each pixel is read from the error and cell memories at the edge it is accepted and is
// modified and written back in the next cycle, when its result, if it completes a cell, is
// pushed into the two-entry output buffer. One pixel is taken every cycle unless the output
// buffer is full, or holds a result while the next one is about to enter it. Reset is
// asynchronous and restores a width of 640 pixels; fill counts make unwritten entries read zero.
module error_diffusion_braille_packer #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [edbp_pkg::IN_TDATA_W-1:0]   s_tdata,   // [7:0] pixel
    input  logic                              s_tuser,   // [0] frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [edbp_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [7:0] braille_dots, [16:8]
                                                         // cell_column, [24:17] cell_row
    input  logic                              cfg_we,
    input  logic [edbp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [edbp_pkg::LINE_WIDTH_W-1:0] cfg_wdata
);
    import edbp_pkg::*;

    localparam int CW         = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int FW         = CW + 1;
    localparam int NW         = CW - 1;
    localparam int RW         = ($clog2(MAX_HEIGHT) > 2) ? $clog2(MAX_HEIGHT) : 2;
    localparam int EMEM_DEPTH = 2 ** (CW + 1);
    localparam int CMEM_DEPTH = 2 ** NW;
    localparam int WMAX_EVEN  = MAX_WIDTH - (MAX_WIDTH % 2);
    localparam int RST_RAW    = int'(LINE_WIDTH_RESET);
    localparam int RESET_W    = (RST_RAW > MAX_WIDTH) ? WMAX_EVEN : (RST_RAW - (RST_RAW % 2));

    // Configuration and position state.
    logic [FW-1:0] eff_width_reg;
    logic          invert_dots_reg;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic          bank_reg;
    logic          bank_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [CW-1:0] cfill_reg;
    logic [CW-1:0] cfill_next;
    logic          s2_valid_reg;
    logic          pend_valid_reg;

    logic [31:0]   cfg_w32;
    logic [FW-1:0] width_raw;
    logic [FW-1:0] width_clamped;

    // Accept-side signals.
    logic          accept;
    logic          fs;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [FW-1:0] col_inc;
    logic          eol;
    logic [FW-1:0] fill_eff;
    logic [CW-1:0] cfill_eff;
    logic [NW-1:0] cur_cell;
    logic [CW-1:0] cell_inc;
    logic [CW:0]   rd_addr;

    // Stage registers of the read-modify-write step.
    logic [7:0]    s2_pixel;
    logic [CW-1:0] s2_col;
    logic          s2_first;
    logic          s2_eol;
    logic          s2_ev;
    logic          s2_cv;
    logic [2:0]    s2_pos;
    logic          s2_last;
    logic          s2_wbank;
    logic [NW-1:0] s2_cell;
    logic [7:0]    s2_crow;
    logic          s2_efwd;
    err_t          s2_efwd_data;
    logic          s2_cfwd;
    logic [7:0]    s2_cfwd_data;

    // Error datapath.
    err_t          carry_reg;
    err_t          part_reg;
    err_t          dr_reg;
    logic [CW:0]   pend_addr_reg;
    err_t          pend_data_reg;
    err_t          e_rd;
    err_t          carry_in;
    err_t          e_in;
    err_wide_t     sum;
    err_wide_t     err_full;
    logic          bright;
    err_t          err;
    err_t          d_half;
    err_t          d_quarter;
    err_t          d_eighth;
    err_t          dr_in;
    err_t          dl_final;
    err_t          part_next;
    err_t          carry_next;
    err_t          dr_next;

    // Memories and their write ports.
    err_t          err_mem [EMEM_DEPTH];
    err_t          err_q;
    logic          ew_en;
    logic [CW:0]   ew_addr;
    err_t          ew_data;
    logic [7:0]    cell_mem [CMEM_DEPTH];
    logic [7:0]    cell_q;
    logic          cw_en;
    logic [NW-1:0] cw_addr;
    logic [7:0]    cw_data;

    // Cell and output.
    logic          dot;
    logic [7:0]    c_old;
    logic [7:0]    c_new;
    logic          res_push;
    cell_result_t  res_data;
    cell_result_t  out_data;
    buf_status_t   buf_status;

    always_comb
    begin
        cfg_w32   = 32'(cfg_wdata);
        width_raw = FW'(cfg_w32);
        if (cfg_w32 < 32'(MIN_LINE_WIDTH))
        begin
            width_clamped = FW'(MIN_LINE_WIDTH);
        end
        else if (cfg_w32 > 32'(MAX_WIDTH))
        begin
            width_clamped = FW'(WMAX_EVEN);
        end
        else
        begin
            width_clamped = {width_raw[FW-1:1], 1'b0};
        end
    end

    assign s_tready = buf_status.empty || (!buf_status.full && !(s2_valid_reg && s2_last));
    assign accept   = s_tvalid && s_tready;
    assign fs       = s_tuser;

    always_comb
    begin
        cur_col   = fs ? '0 : col_reg;
        cur_row   = fs ? '0 : row_reg;
        fill_eff  = fs ? '0 : fill_reg;
        cfill_eff = fs ? '0 : cfill_reg;
        col_inc   = {1'b0, cur_col} + FW'(1);
        eol       = (col_inc >= eff_width_reg);
        cur_cell  = cur_col[CW-1:1];
        cell_inc  = {1'b0, cur_cell} + CW'(1);
        rd_addr   = {bank_reg, cur_col};

        col_next  = eol ? '0 : col_inc[CW-1:0];
        bank_next = eol ? ~bank_reg : bank_reg;
        fill_next = eol ? col_inc : fill_eff;
        if (!eol)
        begin
            row_next = cur_row;
        end
        else if (cur_row == RW'(MAX_HEIGHT - 1))
        begin
            row_next = '0;
        end
        else
        begin
            row_next = cur_row + RW'(1);
        end
        cfill_next = (cell_inc > cfill_eff) ? cell_inc : cfill_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_width_reg   <= FW'(RESET_W);
            invert_dots_reg <= 1'b0;
            col_reg         <= '0;
            row_reg         <= '0;
            bank_reg        <= 1'b0;
            fill_reg        <= '0;
            cfill_reg       <= '0;
            s2_valid_reg    <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_LINE_WIDTH:  eff_width_reg   <= width_clamped;
                    CFG_INVERT_DOTS: invert_dots_reg <= cfg_wdata[0];
                    default:         ;
                endcase
            end
            if (accept)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                bank_reg  <= bank_next;
                fill_reg  <= fill_next;
                cfill_reg <= cfill_next;
            end
            s2_valid_reg   <= accept;
            pend_valid_reg <= s2_valid_reg && s2_eol;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_pixel     <= s_tdata;
            s2_col       <= cur_col;
            s2_first     <= (cur_col == '0);
            s2_eol       <= eol;
            s2_ev        <= ({1'b0, cur_col} < fill_eff);
            s2_cv        <= ({1'b0, cur_cell} < cfill_eff);
            s2_pos       <= {cur_row[1:0], cur_col[0]};
            s2_last      <= ({cur_row[1:0], cur_col[0]} == LAST_POS);
            s2_wbank     <= ~bank_reg;
            s2_cell      <= cur_cell;
            s2_crow      <= 8'(cur_row >> 2);
            s2_efwd      <= ew_en && (ew_addr == rd_addr);
            s2_efwd_data <= ew_data;
            s2_cfwd      <= cw_en && (cw_addr == cur_cell);
            s2_cfwd_data <= cw_data;
        end
        if (s2_valid_reg)
        begin
            carry_reg     <= carry_next;
            part_reg      <= part_next;
            dr_reg        <= dr_next;
            pend_addr_reg <= {s2_wbank, s2_col};
            pend_data_reg <= part_next;
        end
    end

    always_comb
    begin
        e_rd       = s2_ev ? (s2_efwd ? s2_efwd_data : err_q) : ERR_ZERO;
        carry_in   = s2_first ? ERR_ZERO : carry_reg;
        e_in       = sat_err(err_wide_t'(e_rd) + err_wide_t'(carry_in));
        sum        = err_wide_t'({4'b0000, s2_pixel}) + err_wide_t'(e_in);
        bright     = (sum >= THRESHOLD);
        err_full   = bright ? (sum - WHITE_LEVEL) : sum;
        err        = err_t'(err_full);
        d_half     = err >>> 1;
        d_quarter  = err >>> 2;
        d_eighth   = err >>> 3;
        dr_in      = s2_first ? ERR_ZERO : dr_reg;
        dl_final   = sat_err(err_wide_t'(part_reg) + err_wide_t'(d_eighth));
        part_next  = sat_err(err_wide_t'(dr_in) + err_wide_t'(d_quarter));
        carry_next = s2_eol ? ERR_ZERO : d_half;
        dr_next    = s2_eol ? ERR_ZERO : d_eighth;
    end

    // The last entry of a line is written in the following cycle, when the next pixel is
    // always at column zero and leaves the write port free.
    always_comb
    begin
        if (pend_valid_reg)
        begin
            ew_en   = 1'b1;
            ew_addr = pend_addr_reg;
            ew_data = pend_data_reg;
        end
        else
        begin
            ew_en   = s2_valid_reg && !s2_first;
            ew_addr = {s2_wbank, s2_col - CW'(1)};
            ew_data = dl_final;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ew_en)
        begin
            err_mem[ew_addr] <= ew_data;
        end
        if (accept)
        begin
            err_q <= err_mem[rd_addr];
        end
    end

    always_comb
    begin
        dot     = bright ^ invert_dots_reg;
        c_old   = s2_cv ? (s2_cfwd ? s2_cfwd_data : cell_q) : 8'h00;
        c_new   = c_old | (dot ? dot_mask(s2_pos) : 8'h00);
        cw_en   = s2_valid_reg;
        cw_addr = s2_cell;
        cw_data = s2_last ? 8'h00 : c_new;
    end

    always_ff @(posedge clk)
    begin
        if (cw_en)
        begin
            cell_mem[cw_addr] <= cw_data;
        end
        if (accept)
        begin
            cell_q <= cell_mem[cur_cell];
        end
    end

    assign res_push              = s2_valid_reg && s2_last;
    assign res_data.braille_dots = c_new;
    assign res_data.cell_column  = 9'(s2_cell);
    assign res_data.cell_row     = s2_crow;

    edbp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .valid     (m_tvalid),
        .ready     (m_tready),
        .data      (out_data),
        .status    (buf_status)
    );

    assign m_tdata = OUT_TDATA_W'(out_data);

endmodule

// File: rtl/edbp_out_buf.sv
// Two-entry output buffer that decouples the result stage from the output stream.
module edbp_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  edbp_pkg::cell_result_t push_data,
    output logic                   valid,
    input  logic                   ready,
    output edbp_pkg::cell_result_t data,
    output edbp_pkg::buf_status_t  status
);
    import edbp_pkg::*;

    cell_result_t entry_reg [2];
    logic         head_reg;
    logic         head_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         tail;
    logic         pop;

    assign valid        = (count_reg != 2'd0);
    assign pop          = valid && ready;
    assign tail         = head_reg ^ count_reg[0];
    assign data         = entry_reg[head_reg];
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);

    always_comb
    begin
        head_next = pop ? ~head_reg : head_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail] <= push_data;
        end
    end

endmodule

// File: rtl/edbp_checker.sv
// Port-level checker of the braille packer and its bind to the top level.
`include "error_diffusion_braille_packer_macros.svh"

module edbp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [edbp_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import edbp_pkg::*;

    // A stalled result transaction keeps its data.
    `EDBP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The bits above the result fields are always zero.
    `EDBP_ASSERT_SAME(a_out_pad, m_tvalid, m_tdata[OUT_TDATA_W-1:RESULT_W] == '0)

    // A result follows only an accepted pixel, through the stage and buffer registers.
    `EDBP_ASSERT_SAME(a_out_cause, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

    // Input is held off only while a result is waiting.
    `EDBP_ASSERT_SAME(a_stall_reason, !s_tready, m_tvalid)

endmodule

bind error_diffusion_braille_packer edbp_checker u_edbp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/error_diffusion_braille_packer_tb.sv
// Self-checking testbench of the error-diffusion braille packer, with a behavioural predictor.
module error_diffusion_braille_packer_tb;
    import edbp_pkg::*;

    localparam int MAX_W      = 1024;
    localparam int MAX_H      = 1024;
    localparam int CYCLE_CAP  = 500000;
    localparam int TAIL_WAIT  = 8;
    localparam int RAND_ITEMS = 400;
    localparam logic [63:0] DOT_BITS =
        {8'h80, 8'h40, 8'h20, 8'h04, 8'h10, 8'h02, 8'h08, 8'h01};

    typedef struct {
        logic [7:0] pixel;
        logic       frame_start;
    } pixel_item_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [LINE_WIDTH_W-1:0] cfg_wdata = '0;

    pixel_item_t  pixel_q[$];
    cell_result_t pending_cells[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    bit           bursts_on = 1'b1;
    int           src_gap = 0;
    int           sink_gap = 0;

    logic [LINE_WIDTH_W-1:0] width_reg;
    logic                    invert_reg;
    err_t                    err_cur [MAX_W];
    err_t                    err_nxt [MAX_W];
    err_t                    err_carry;
    logic [7:0]              cell_acc [MAX_W/2];
    int                      col_pos;
    int                      row_pos;

    error_diffusion_braille_packer #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] pixel
        .s_tuser   (s_tuser),   // [0] frame_start
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [7:0] braille_dots, [16:8] cell_column, [24:17] cell_row
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic int clip_err(input int v);
        int r;
        r = v;
        if (v > 1023)
        begin
            r = 1023;
        end
        else if (v < -1024)
        begin
            r = -1024;
        end
        return r;
    endfunction

    task automatic clear_frame();
        for (int i = 0; i < MAX_W; i++)
        begin
            err_cur[i] = ERR_ZERO;
            err_nxt[i] = ERR_ZERO;
        end
        for (int i = 0; i < MAX_W/2; i++)
        begin
            cell_acc[i] = 8'h00;
        end
        err_carry = ERR_ZERO;
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic predict_pixel(input logic [7:0] pix, input logic start);
        int         w;
        int         c;
        int         r;
        int         e_in;
        int         sum;
        int         err;
        logic       bright;
        logic [2:0] pos;
        logic [8:0] cell_idx;
        cell_result_t res;
        if (start)
        begin
            clear_frame();
        end
        w = int'(width_reg);
        if (w < MIN_LINE_WIDTH)
        begin
            w = MIN_LINE_WIDTH;
        end
        if (w > MAX_W)
        begin
            w = MAX_W;
        end
        w = w & ~1;
        c = col_pos;
        r = row_pos;
        if (c >= MAX_W)
        begin
            c = MAX_W - 1;
        end
        e_in = clip_err(int'(err_cur[c]) + int'(err_carry));
        sum = int'(pix) + e_in;
        bright = (sum >= int'(THRESHOLD));
        err = sum - (bright ? int'(WHITE_LEVEL) : 0);
        err_carry = (c + 1 < w) ? err_t'(clip_err(err >>> 1)) : ERR_ZERO;
        if (c > 0)
        begin
            err_nxt[c-1] = err_t'(clip_err(int'(err_nxt[c-1]) + (err >>> 3)));
        end
        err_nxt[c] = err_t'(clip_err(int'(err_nxt[c]) + (err >>> 2)));
        if (c + 1 < w)
        begin
            err_nxt[c+1] = err_t'(clip_err(int'(err_nxt[c+1]) + (err >>> 3)));
        end
        cell_idx = c[9:1];
        pos = {r[1:0], c[0]};
        if (bright ^ invert_reg)
        begin
            cell_acc[cell_idx] = cell_acc[cell_idx] | DOT_BITS[pos*8 +: 8];
        end
        if (pos == LAST_POS)
        begin
            res.braille_dots = cell_acc[cell_idx];
            res.cell_column = cell_idx;
            res.cell_row = r[9:2];
            pending_cells.push_back(res);
            cell_acc[cell_idx] = 8'h00;
        end
        if (c + 1 >= w)
        begin
            for (int i = 0; i < MAX_W; i++)
            begin
                err_cur[i] = err_nxt[i];
                err_nxt[i] = ERR_ZERO;
            end
            err_carry = ERR_ZERO;
            col_pos = 0;
            row_pos = (r + 1 >= MAX_H) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    // The predictor follows register writes and accepted pixels at the edges the block sees them.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_LINE_WIDTH)
                begin
                    width_reg = cfg_wdata;
                end
                else if (cfg_index == CFG_INVERT_DOTS)
                begin
                    invert_reg = cfg_wdata[0];
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_pixel(s_tdata[7:0], s_tuser);
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    src_gap--;
                end
                else if (pixel_q.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pixel_q[0].pixel;
                    s_tuser <= pixel_q[0].frame_start;
                    void'(pixel_q.pop_front());
                    if (bursts_on && $urandom_range(0, 7) == 0)
                    begin
                        src_gap = $urandom_range(1, 9);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cell_result_t got;
        cell_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = cell_result_t'(m_tdata[RESULT_W-1:0]);
                if (pending_cells.size() == 0)
                begin
                    $error("unexpected cell transaction: dots %0h column %0d row %0d",
                           got.braille_dots, got.cell_column, got.cell_row);
                    fail_count++;
                end
                else
                begin
                    want = pending_cells.pop_front();
                    if (got.braille_dots !== want.braille_dots)
                    begin
                        $error("braille_dots: expected %0h, actual %0h",
                               want.braille_dots, got.braille_dots);
                        fail_count++;
                    end
                    if (got.cell_column !== want.cell_column)
                    begin
                        $error("cell_column: expected %0d, actual %0d",
                               want.cell_column, got.cell_column);
                        fail_count++;
                    end
                    if (got.cell_row !== want.cell_row)
                    begin
                        $error("cell_row: expected %0d, actual %0d",
                               want.cell_row, got.cell_row);
                        fail_count++;
                    end
                end
            end
            if (sink_gap > 0)
            begin
                m_tready <= 1'b0;
                sink_gap--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (bursts_on && $urandom_range(0, 7) == 0)
                begin
                    sink_gap = $urandom_range(1, 9);
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_CAP)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("error_diffusion_braille_packer: mismatch");
        $finish;
    end

    task automatic write_reg(input cfg_index_t idx, input logic [LINE_WIDTH_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_pixel(input logic [7:0] pix, input logic start);
        pixel_item_t item;
        item.pixel = pix;
        item.frame_start = start;
        pixel_q.push_back(item);
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_tvalid || pending_cells.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_WAIT) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_pixel();
        logic [7:0] p;
        case ($urandom_range(0, 7))
            0:       p = 8'd0;
            1:       p = 8'd255;
            2:       p = 8'd127 + 8'($urandom_range(0, 1));
            default: p = 8'($urandom_range(0, 255));
        endcase
        return p;
    endfunction

    initial
    begin
        int done_items;
        int len;
        logic [LINE_WIDTH_W-1:0] lw;
        width_reg = LINE_WIDTH_RESET;
        invert_reg = 1'b0;
        clear_frame();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // A few pixels at the reset width, so the next width write cuts the line short.
        queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd128, 1'b0);
        queue_pixel(8'd127, 1'b0);
        wait_drained();
        write_reg(CFG_LINE_WIDTH, 11'd2);
        write_reg(CFG_INVERT_DOTS, 11'd0);
        queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd127, 1'b0);
        wait_drained();
        write_reg(CFG_INVERT_DOTS, 11'd1);
        queue_pixel(8'd128, 1'b0);
        queue_pixel(8'd127, 1'b0);
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd0, 1'b1);
        queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd128, 1'b0);
        queue_pixel(8'd127, 1'b0);
        queue_pixel(8'd1, 1'b0);
        queue_pixel(8'd254, 1'b0);
        queue_pixel(8'd64, 1'b0);
        queue_pixel(8'd192, 1'b0);
        wait_drained();

        done_items = 0;
        while (done_items < RAND_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       lw = 11'($urandom_range(0, 2047));
                1:
                begin
                    case ($urandom_range(0, 5))
                        0:       lw = 11'd0;
                        1:       lw = 11'd1;
                        2:       lw = 11'd1024;
                        3:       lw = 11'd1025;
                        4:       lw = 11'd2047;
                        default: lw = 11'd3;
                    endcase
                end
                default: lw = 11'($urandom_range(2, 16));
            endcase
            write_reg(CFG_LINE_WIDTH, lw);
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(CFG_INVERT_DOTS, 11'($urandom_range(0, 1)));
            end
            len = $urandom_range(24, 120);
            for (int k = 0; k < len; k++)
            begin
                queue_pixel(pick_pixel(),
                            (k == 0 && $urandom_range(0, 3) == 0) || $urandom_range(0, 63) == 0);
            end
            done_items += len;
            wait_drained();
        end

        // Three short lines, then one full-width line that completes every cell column.
        write_reg(CFG_LINE_WIDTH, 11'd2);
        write_reg(CFG_INVERT_DOTS, 11'd0);
        for (int k = 0; k < 6; k++)
        begin
            queue_pixel(pick_pixel(), k == 0);
        end
        wait_drained();
        bursts_on = 1'b0;
        write_reg(CFG_LINE_WIDTH, 11'd2047);
        for (int k = 0; k < MAX_W; k++)
        begin
            queue_pixel(pick_pixel(), 1'b0);
        end
        wait_drained();

        if (fail_count == 0)
        begin
            $display("error_diffusion_braille_packer: match");
        end
        else
        begin
            $display("error_diffusion_braille_packer: mismatch");
        end
        $finish;
    end

endmodule
